### rtl/core/skf_pkg.sv
// Shared widths, register codes, state type and format conversions for the
// scalar Kalman filter core. No dependencies.
`default_nettype none

package skf_pkg;

	localparam int FRAC_BITS = 24;
	localparam int NOISE_W   = 24;
	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 25;
	localparam int EST_W     = 32;
	localparam int COV_W     = FRAC_BITS + 1;
	localparam int K_W       = FRAC_BITS + 1;
	localparam int PP_W      = FRAC_BITS + 2;
	localparam int DEN_W     = FRAC_BITS + 3;
	localparam int REM_W     = FRAC_BITS + 4;
	localparam int MAG_W     = EST_W + 1;
	localparam int CNT_W     = $clog2(K_W);
	localparam int CFG_IDX_W = 1;

	localparam logic [K_W-1:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

	localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 24'd1678;
	localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 24'd83886;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} skf_state_t;

	function automatic logic [FRAC_BITS-1:0] noise_to_f(input logic [NOISE_W-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		if (FRAC_BITS >= NOISE_W) begin
			t = t << (FRAC_BITS - NOISE_W);
		end else begin
			t = t >> (NOISE_W - FRAC_BITS);
		end
		return t[FRAC_BITS-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] gain_to_out(input logic [K_W-1:0] g);
		logic [63:0] t;
		t = 64'(g);
		if (FRAC_BITS >= NOISE_W) begin
			t = t >> (FRAC_BITS - NOISE_W);
		end else begin
			t = t << (NOISE_W - FRAC_BITS);
		end
		return t[GAIN_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/core/skf_div.sv
// Restoring divider for the filter gain, one quotient bit per cycle.
// Depends on skf_pkg.
`default_nettype none

module skf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [skf_pkg::PP_W-1:0]   dividend,
	input  logic [skf_pkg::DEN_W-1:0]  divisor,
	output logic                       done,
	output logic [skf_pkg::K_W-1:0]    quotient
);
	import skf_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [K_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic             ge;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] rem_nxt;

	always_comb begin
		ge      = rem_q >= REM_W'(den_q);
		trial   = rem_q - REM_W'(den_q);
		rem_nxt = ge ? trial : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REM_W'(dividend);
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_nxt[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[K_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### rtl/core/skf_mul.sv
// Two-lane shift-and-add multiplier that scans the gain and one minus the gain one bit per cycle,
// giving the estimate correction and the new covariance. Depends on skf_pkg.
`default_nettype none

module skf_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [skf_pkg::MAG_W-1:0]  mag,
	input  logic [skf_pkg::PP_W-1:0]   pp,
	input  logic [skf_pkg::K_W-1:0]    k,
	output logic                       done,
	output logic [skf_pkg::MAG_W-1:0]  corr,
	output logic [skf_pkg::COV_W-1:0]  cov_new
);
	import skf_pkg::*;

	logic [MAG_W-1:0] mag_q;
	logic [PP_W-1:0]  pp_q;
	logic [K_W-1:0]   ka_q;
	logic [K_W-1:0]   kb_q;
	logic [MAG_W:0]   acc_a_q;
	logic [PP_W:0]    acc_b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [MAG_W:0] sum_a;
	logic [PP_W:0]  sum_b;

	always_comb begin
		sum_a = acc_a_q + (ka_q[0] ? {1'b0, mag_q} : '0);
		sum_b = acc_b_q + (kb_q[0] ? {1'b0, pp_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q   <= mag;
			pp_q    <= pp;
			ka_q    <= k;
			kb_q    <= ONE_F - k;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (busy_q) begin
			ka_q <= ka_q >> 1;
			kb_q <= kb_q >> 1;
			if (cnt_q == '0) begin
				acc_a_q <= sum_a;
				acc_b_q <= sum_b;
			end else begin
				acc_a_q <= sum_a >> 1;
				acc_b_q <= sum_b >> 1;
			end
		end
	end

	assign done    = done_q;
	assign corr    = acc_a_q[MAG_W-1:0];
	assign cov_new = acc_b_q[COV_W-1:0];

endmodule

`default_nettype wire

### rtl/core/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter core: sequencer, state, registers.
// Depends on skf_pkg, skf_div and skf_mul.
// Each accepted speed sample passes through the prepare, divide, multiply and
// done states before its result is ready; the serial divider and the serial
// multiplier each handle one gain bit per cycle. One sample is in work at a
// time; a finished result sits in the output register so the next sample can
// be taken while it waits. Noise registers may be written only while the core
// is idle.
`default_nettype none

module scalar_kalman_filter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [skf_pkg::NOISE_W-1:0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [skf_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [skf_pkg::SAMPLE_W-1:0] filtered,
	output logic [skf_pkg::GAIN_W-1:0]         gain
);
	import skf_pkg::*;

	skf_state_t state_q, state_nxt;

	logic [NOISE_W-1:0]  q_noise_q;
	logic [NOISE_W-1:0]  r_noise_q;
	logic [EST_W-1:0]    est_q;
	logic [COV_W-1:0]    cov_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [PP_W-1:0]     pp_q;
	logic [MAG_W-1:0]    mag_q;
	logic                neg_q;
	logic [K_W-1:0]      k_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] filtered_q;
	logic [GAIN_W-1:0]   gain_q;

	logic                accept;
	logic                div_start;
	logic                mul_start;
	logic                est_load;
	logic                out_load;

	logic [DEN_W-1:0]    den;
	logic                div_done;
	logic [K_W-1:0]      div_quo;
	logic [K_W-1:0]      k_clamp;
	logic                mul_done;
	logic [MAG_W-1:0]    corr;
	logic [COV_W-1:0]    cov_new;

	logic [MAG_W-1:0]    diff;
	logic [MAG_W:0]      est_sum;
	logic [EST_W:0]      est_ext;
	logic [EST_W:0]      est_abs;
	logic [SAMPLE_W:0]   int_abs;
	logic [SAMPLE_W:0]   int_val;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: state_nxt = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		est_load  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: in_stall  = 1'b0;
			ST_PREP: div_start = 1'b1;
			ST_DIV:  mul_start = div_done;
			ST_MUL:  est_load  = mul_done;
			ST_DONE: out_load  = !out_valid_q || !out_stall;
			default: in_stall  = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= PROCESS_NOISE_RST;
			r_noise_q <= MEASUREMENT_NOISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROCESS_NOISE:     q_noise_q <= cfg_wdata;
				REG_MEASUREMENT_NOISE: r_noise_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		den     = DEN_W'(pp_q) + DEN_W'(noise_to_f(r_noise_q));
		diff    = {sample_q[SAMPLE_W-1], sample_q, 16'd0} - {est_q[EST_W-1], est_q};
		k_clamp = (div_quo > ONE_F) ? ONE_F : div_quo;
		est_sum = neg_q ? ({{2{est_q[EST_W-1]}}, est_q} - {1'b0, corr})
		                : ({{2{est_q[EST_W-1]}}, est_q} + {1'b0, corr});
		est_ext = {est_q[EST_W-1], est_q};
		est_abs = est_q[EST_W-1] ? (-est_ext) : est_ext;
		int_abs = est_abs[EST_W:16];
		int_val = est_q[EST_W-1] ? (-int_abs) : int_abs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			cov_q <= '0;
		end else if (est_load) begin
			est_q <= est_sum[EST_W-1:0];
			cov_q <= cov_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			pp_q     <= PP_W'(cov_q) + PP_W'(noise_to_f(q_noise_q));
		end
		if (div_start) begin
			neg_q <= diff[MAG_W-1];
			mag_q <= diff[MAG_W-1] ? (-diff) : diff;
		end
		if (mul_start) begin
			k_q <= k_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered_q <= int_val[SAMPLE_W-1:0];
			gain_q     <= gain_to_out(k_q);
		end
	end

	skf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pp_q),
		.divisor  (den),
		.done     (div_done),
		.quotient (div_quo)
	);

	skf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mag     (mag_q),
		.pp      (pp_q),
		.k       (k_clamp),
		.done    (mul_done),
		.corr    (corr),
		.cov_new (cov_new)
	);

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign gain      = gain_q;

`ifndef SYNTHESIS
	a_gain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> k_q <= ONE_F)
		else $error("gain above one during multiply");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished item");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire
